// ===== design/ppct_pkg.sv =====
// ppct_pkg: shared constants and types for the point-in-path crossing test
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ppct_pkg;

    // apb register map, word index taken from paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TEST_X = 1'b0;
    localparam logic REG_TEST_Y = 1'b1;

    // result word carries only the inside flag in bit 0
    localparam int OUT_TDATA_W = 8;

    // control that travels with the registered edge products
    typedef struct packed {
        logic valid;
        logic straddle;
        logic dy_pos;
        logic last;
    } ppct_edge_ctl_t;

endpackage

// ===== design/ppct_edge_mul.sv =====
// ppct_edge_mul: edge differences, straddle test and the two cross products
// depends on ppct_pkg; registers products and control for the compare stage
`timescale 1ns / 1ps

module ppct_edge_mul #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [COORD_WIDTH-1:0]  ax,
    input  logic signed [COORD_WIDTH-1:0]  ay,
    input  logic signed [COORD_WIDTH-1:0]  bx,
    input  logic signed [COORD_WIDTH-1:0]  by,
    input  logic                           draw,
    input  logic                           last,
    input  logic signed [COORD_WIDTH-1:0]  test_x,
    input  logic signed [COORD_WIDTH-1:0]  test_y,
    output ppct_pkg::ppct_edge_ctl_t       ctl,
    output logic signed [2*COORD_WIDTH+1:0] prod_p,
    output logic signed [2*COORD_WIDTH+1:0] prod_b
);
    import ppct_pkg::*;

    localparam int D = COORD_WIDTH + 1;
    localparam int P = 2 * D;

    logic signed [D-1:0] dy;
    logic signed [D-1:0] dxp;
    logic signed [D-1:0] dxb;
    logic signed [D-1:0] dpy;
    logic signed [P-1:0] prod_p_next;
    logic signed [P-1:0] prod_b_next;
    logic signed [P-1:0] prod_p_reg;
    logic signed [P-1:0] prod_b_reg;
    ppct_edge_ctl_t      ctl_next;
    ppct_edge_ctl_t      ctl_reg;

    always_comb begin
        dy  = D'(by) - D'(ay);
        dxp = D'(test_x) - D'(ax);
        dxb = D'(bx) - D'(ax);
        dpy = D'(test_y) - D'(ay);
        prod_p_next = P'(dxp) * P'(dy);
        prod_b_next = P'(dxb) * P'(dpy);
        ctl_next.valid    = in_valid;
        // exactly one end strictly above the test height
        ctl_next.straddle = draw && ((ay > test_y) != (by > test_y));
        ctl_next.dy_pos   = dy > D'(0);
        ctl_next.last     = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_p_reg <= prod_p_next;
            prod_b_reg <= prod_b_next;
        end
    end

    assign ctl    = ctl_reg;
    assign prod_p = prod_p_reg;
    assign prod_b = prod_b_reg;

endmodule

// ===== design/ppct_parity.sv =====
// ppct_parity: product compare, crossing parity and the result register
// depends on ppct_pkg; fed by ppct_edge_mul
`timescale 1ns / 1ps

module ppct_parity #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  ppct_pkg::ppct_edge_ctl_t        ctl,
    input  logic signed [2*COORD_WIDTH+1:0] prod_p,
    input  logic signed [2*COORD_WIDTH+1:0] prod_b,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic                            inside_flag
);
    import ppct_pkg::*;

    logic left;
    logic toggle;
    logic parity_reg;
    logic parity_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic inside_reg;
    logic inside_next;
    logic flag;

    always_comb begin
        // comparison direction flips with the sign of dy
        left   = ctl.dy_pos ? (prod_p < prod_b) : (prod_b < prod_p);
        toggle = ctl.straddle && left;
        flag   = parity_reg ^ toggle;

        parity_next    = parity_reg;
        out_valid_next = out_valid_reg;
        inside_next    = inside_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (en && ctl.valid) begin
            if (ctl.last) begin
                parity_next    = 1'b0;
                out_valid_next = 1'b1;
                inside_next    = flag;
            end else begin
                parity_next = flag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inside_reg <= inside_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign inside_flag = inside_reg;

endmodule

// ===== design/point_in_path_crossing_test_unit.sv =====
// point_in_path_crossing_test_unit: even-odd crossing test of a configured point
// a last vertex sets m_tvalid from the result register; one vertex per cycle unless stalled
// pipeline: input register, product register (two multipliers), parity/result register
// the pipeline stalls only while a finished result waits and another one is due
// reset: synchronous active-low aresetn clears test point, previous vertex and parity
// depends on ppct_pkg, ppct_edge_mul, ppct_parity
`timescale 1ns / 1ps

module point_in_path_crossing_test_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // s_tdata: vertex_x, vertex_y, zero fill
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    // s_tuser: mode
    input  logic                                        s_tuser,
    // s_tlast: path_end
    input  logic                                        s_tlast,
    // m_tdata: inside_res, zero fill
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [ppct_pkg::OUT_TDATA_W-1:0]            m_tdata,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [ppct_pkg::APB_ADDR_W-1:0]             paddr,
    input  logic [ppct_pkg::APB_DATA_W-1:0]             pwdata,
    output logic [ppct_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                        pready
);
    import ppct_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] test_x_reg;
    logic signed [W-1:0] test_y_reg;
    logic signed [W-1:0] prev_x_reg;
    logic signed [W-1:0] prev_y_reg;
    logic signed [W-1:0] ax_reg;
    logic signed [W-1:0] ay_reg;
    logic signed [W-1:0] bx_reg;
    logic signed [W-1:0] by_reg;
    logic                draw_reg;
    logic                last_reg;
    logic                s0_valid_reg;
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    logic                en;
    logic                accept;
    logic                cfg_wr;
    logic                inside_flag;
    ppct_edge_ctl_t      edge_ctl;
    logic signed [2*W+1:0] prod_p;
    logic signed [2*W+1:0] prod_b;

    assign in_x = s_tdata[W-1:0];
    assign in_y = s_tdata[2*W-1:W];

    // hold everything only when a last word must enter a full result slot
    assign en       = !(edge_ctl.valid && edge_ctl.last && m_tvalid && !m_tready);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_x_reg <= '0;
            test_y_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TEST_X: test_x_reg <= pwdata[W-1:0];
                REG_TEST_Y: test_y_reg <= pwdata[W-1:0];
                default:    test_x_reg <= test_x_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TEST_X: prdata = APB_DATA_W'(test_x_reg);
            REG_TEST_Y: prdata = APB_DATA_W'(test_y_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
            if (s_tvalid) begin
                // the path restarts at the origin after its last vertex
                prev_x_reg <= s_tlast ? '0 : in_x;
                prev_y_reg <= s_tlast ? '0 : in_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ax_reg   <= prev_x_reg;
            ay_reg   <= prev_y_reg;
            bx_reg   <= in_x;
            by_reg   <= in_y;
            draw_reg <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    ppct_edge_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s0_valid_reg),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .bx       (bx_reg),
        .by       (by_reg),
        .draw     (draw_reg),
        .last     (last_reg),
        .test_x   (test_x_reg),
        .test_y   (test_y_reg),
        .ctl      (edge_ctl),
        .prod_p   (prod_p),
        .prod_b   (prod_b)
    );

    ppct_parity #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_parity (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .ctl         (edge_ctl),
        .prod_p      (prod_p),
        .prod_b      (prod_b),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .inside_flag (inside_flag)
    );

    assign m_tdata = OUT_TDATA_W'(inside_flag);

endmodule

// ===== design/ppct_checker.sv =====
// ppct_checker: port-level assertions for point_in_path_crossing_test_unit
// depends on ppct_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module ppct_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppct_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ppct_pkg::*;

    // a waiting result holds its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // only the flag bit may be set
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("result fill bits not zero");

    // input side never waits on an empty result slot
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // a fresh result comes from a previously accepted last word
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 3))
        else $error("result without a preceding last word");

endmodule

bind point_in_path_crossing_test_unit ppct_checker u_ppct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
